>>> hdl/named_counting_semaphore_table_assert.svh
// assertion macros for the named semaphore table and its checker
// expects clk_i and rst_ni in the scope where a macro is used
`ifndef NAMED_COUNTING_SEMAPHORE_TABLE_ASSERT_SVH
`define NAMED_COUNTING_SEMAPHORE_TABLE_ASSERT_SVH

// same-cycle implication, disabled during reset
`define NCST_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define NCST_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/nsem_pkg.sv
// shared types and constants of the named semaphore table
// no dependencies
package nsem_pkg;

  localparam int unsigned NumEntriesDef = 16;
  localparam int unsigned QueueDepthDef = 16;
  localparam int unsigned NameBitsDef   = 64;
  localparam int unsigned EnvIdBitsDef  = 10;

  // field widths of the beats
  localparam int unsigned FuncW    = 2;
  localparam int unsigned OwnerW   = 10;
  localparam int unsigned NameW    = 64;
  localparam int unsigned InitW    = 16;
  localparam int unsigned EnvW     = 10;
  localparam int unsigned TargetW  = 4;
  localparam int unsigned StatusW  = 3;
  localparam int unsigned IdxW     = 4;
  localparam int unsigned CountW   = 17;
  localparam int unsigned InDataW  = 112;
  localparam int unsigned OutDataW = 24;

  // input field offsets in tdata
  localparam int unsigned FuncLo   = 0;
  localparam int unsigned OwnerLo  = FuncLo + FuncW;
  localparam int unsigned NameLo   = OwnerLo + OwnerW;
  localparam int unsigned InitLo   = NameLo + NameW;
  localparam int unsigned CallerLo = InitLo + InitW;
  localparam int unsigned TargetLo = CallerLo + EnvW;

  localparam logic signed [CountW-1:0] CountMax = 17'sd65535;

  typedef enum logic [FuncW-1:0] {
    FUNC_CREATE,
    FUNC_WAIT,
    FUNC_SIGNAL,
    FUNC_FREE
  } func_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK,
    ST_EXISTS,
    ST_FULL,
    ST_NOTFOUND,
    ST_QFULL
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_EXEC,
    S_WREAD,
    S_RESP
  } seq_state_e;

  typedef struct packed {
    status_e         status;
    logic [IdxW-1:0] result_index;
    logic            caller_blocked;
    logic            woken_valid;
    logic [EnvW-1:0] woken_env;
  } result_t;

endpackage

>>> hdl/named_counting_semaphore_table.sv
// top level of the named counting semaphore table
// depends on nsem_pkg and nsem_seq (which holds the entry and waiter rams)
//
// One operation per input beat (create, wait, signal, free), one result beat
// per operation. A create, wait or signal walks the entry ram one entry per
// cycle to find the lowest used entry with the same owner and name, and the
// lowest free entry, then executes the operation; a signal that releases a
// waiter also passes through the S_WREAD state, because the waiter ram is
// read after the scan. A free skips the scan and goes straight to execution.
// Operations run one at a time; a new beat is taken as soon
// as the previous result sits in the output register, even if the sink has
// not taken it yet. Each entry keeps a signed count and a ring of up to
// QUEUE_DEPTH blocked caller IDs; a wait on a full ring reports queue full
// and changes nothing. Freeing an entry drops its waiters. There is no
// clearing pass: only the used bits are reset, entry contents are rewritten
// on create.
module named_counting_semaphore_table #(
  parameter int unsigned NUM_ENTRIES = nsem_pkg::NumEntriesDef,
  parameter int unsigned QUEUE_DEPTH = nsem_pkg::QueueDepthDef,
  parameter int unsigned NAME_BITS   = nsem_pkg::NameBitsDef,
  parameter int unsigned ENV_ID_BITS = nsem_pkg::EnvIdBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // func, owner_id, name_key, initial_value, caller_env, target_index, zero pad
  input  logic [nsem_pkg::InDataW-1:0]  s_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // status, result_index, caller_blocked, woken_valid, woken_env, zero pad
  output logic [nsem_pkg::OutDataW-1:0] m_axis_tdata
);

  localparam int unsigned ResW = nsem_pkg::StatusW + nsem_pkg::IdxW + 2 + nsem_pkg::EnvW;

  logic              res_valid, res_ready;
  nsem_pkg::result_t res;
  logic              out_valid_q;
  logic [nsem_pkg::OutDataW-1:0] out_data_q;

  nsem_seq #(
    .NUM_ENTRIES (NUM_ENTRIES),
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .NAME_BITS   (NAME_BITS),
    .ENV_ID_BITS (ENV_ID_BITS)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_data_i   (s_axis_tdata),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  // output register frees the sequencer while the sink stalls
  assign res_ready = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_data_q <= {(nsem_pkg::OutDataW - ResW)'(0), res.woken_env, res.woken_valid,
                     res.caller_blocked, res.result_index, res.status};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

>>> hdl/nsem_ram.sv
// generic single-write, single-read synchronous ram with registered read
// no dependencies
module nsem_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hdl/nsem_seq.sv
// operation sequencer: key scan, count update and wait queue access
// depends on nsem_pkg and nsem_ram
module nsem_seq #(
  parameter int unsigned NUM_ENTRIES = nsem_pkg::NumEntriesDef,
  parameter int unsigned QUEUE_DEPTH = nsem_pkg::QueueDepthDef,
  parameter int unsigned NAME_BITS   = nsem_pkg::NameBitsDef,
  parameter int unsigned ENV_ID_BITS = nsem_pkg::EnvIdBitsDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [nsem_pkg::InDataW-1:0] in_data_i,
  output logic                         res_valid_o,
  input  logic                         res_ready_i,
  output nsem_pkg::result_t            res_o
);

  localparam int unsigned IW  = $clog2(NUM_ENTRIES);
  localparam int unsigned QW  = $clog2(QUEUE_DEPTH);
  localparam int unsigned FW  = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned EW  = (ENV_ID_BITS < nsem_pkg::EnvW) ? ENV_ID_BITS : nsem_pkg::EnvW;
  localparam int unsigned NB  = NAME_BITS;
  localparam int unsigned CW  = nsem_pkg::CountW;
  localparam int unsigned WD  = NUM_ENTRIES * QUEUE_DEPTH;
  localparam int unsigned WW  = $clog2(WD);
  localparam int unsigned NmLo = EW;
  localparam int unsigned CtLo = EW + NB;
  localparam int unsigned HdLo = CtLo + CW;
  localparam int unsigned FlLo = HdLo + QW;
  localparam int unsigned EntW = FlLo + FW;

  nsem_pkg::seq_state_e state_q, state_d;

  logic [IW-1:0] scan_cnt_q, scan_cnt_d;
  logic          issue_done_q, issue_done_d;
  logic          cmp_v_q, cmp_v_d;
  logic [IW-1:0] cmp_idx_q, cmp_idx_d;
  logic          found_q, found_d;
  logic          free_found_q, free_found_d;
  logic [IW-1:0] free_idx_q, free_idx_d;
  logic [IW-1:0] m_idx_q, m_idx_d;
  logic signed [CW-1:0] m_count_q, m_count_d;
  logic [QW-1:0] m_head_q, m_head_d;
  logic [FW-1:0] m_fill_q, m_fill_d;
  logic          used_q [NUM_ENTRIES];

  nsem_pkg::func_e      op_func_q;
  logic [EW-1:0]        op_owner_q;
  logic [NB-1:0]        op_name_q;
  logic [nsem_pkg::InitW-1:0]   op_init_q;
  logic [EW-1:0]        op_caller_q;
  logic [nsem_pkg::TargetW-1:0] op_target_q;
  nsem_pkg::result_t    res_q, res_d;

  logic            accept;
  logic            used_set, used_clr;
  logic [IW-1:0]   used_idx;

  // entry ram ports
  logic            ent_we, ent_re;
  logic [IW-1:0]   ent_waddr, ent_raddr;
  logic [EntW-1:0] ent_wdata, ent_rdata;
  // waiter ram ports
  logic            wt_we, wt_re;
  logic [WW-1:0]   wt_waddr, wt_raddr;
  logic [EW-1:0]   wt_wdata, wt_rdata;

  logic [EW-1:0]        ent_owner;
  logic [NB-1:0]        ent_name;
  logic signed [CW-1:0] ent_count;
  logic [QW-1:0]        ent_head;
  logic [FW-1:0]        ent_fill;
  logic                 hit, free_hit;

  logic [WW-1:0]        q_base;
  logic [QW:0]          slot_sum;
  logic [QW-1:0]        slot;
  logic signed [CW-1:0] sig_count;
  logic [QW-1:0]        head_nx;

  assign accept    = in_valid_i && in_ready_o;
  assign ent_owner = ent_rdata[0 +: EW];
  assign ent_name  = ent_rdata[NmLo +: NB];
  assign ent_count = ent_rdata[CtLo +: CW];
  assign ent_head  = ent_rdata[HdLo +: QW];
  assign ent_fill  = ent_rdata[FlLo +: FW];

  assign hit      = cmp_v_q && used_q[cmp_idx_q] && (ent_owner == op_owner_q)
                    && (ent_name == op_name_q);
  assign free_hit = cmp_v_q && !used_q[cmp_idx_q];

  // queue slot arithmetic, head stays below the depth and fill at most reaches it
  assign q_base   = WW'(WW'(m_idx_q) * WW'(QUEUE_DEPTH));
  assign slot_sum = (QW + 1)'(m_head_q) + (QW + 1)'(m_fill_q);
  assign slot     = (slot_sum >= (QW + 1)'(QUEUE_DEPTH)) ?
                    QW'(slot_sum - (QW + 1)'(QUEUE_DEPTH)) : QW'(slot_sum);
  assign head_nx  = (m_head_q == QW'(QUEUE_DEPTH - 1)) ? '0 : m_head_q + QW'(1);
  assign sig_count = (m_count_q < nsem_pkg::CountMax) ? m_count_q + CW'(1) : m_count_q;

  always_comb begin
    state_d      = state_q;
    scan_cnt_d   = scan_cnt_q;
    issue_done_d = issue_done_q;
    cmp_v_d      = 1'b0;
    cmp_idx_d    = cmp_idx_q;
    found_d      = found_q;
    free_found_d = free_found_q;
    free_idx_d   = free_idx_q;
    m_idx_d      = m_idx_q;
    m_count_d    = m_count_q;
    m_head_d     = m_head_q;
    m_fill_d     = m_fill_q;
    res_d        = res_q;
    used_set     = 1'b0;
    used_clr     = 1'b0;
    used_idx     = m_idx_q;
    ent_we       = 1'b0;
    ent_re       = 1'b0;
    ent_waddr    = m_idx_q;
    ent_raddr    = scan_cnt_q;
    ent_wdata    = {m_fill_q, m_head_q, m_count_q, op_name_q, op_owner_q};
    wt_we        = 1'b0;
    wt_re        = 1'b0;
    wt_waddr     = q_base + WW'(slot);
    wt_raddr     = q_base + WW'(m_head_q);
    wt_wdata     = op_caller_q;
    in_ready_o   = 1'b0;
    res_valid_o  = 1'b0;

    unique case (state_q)
      nsem_pkg::S_IDLE: begin
        // no beat is taken while in reset
        in_ready_o = rst_ni;
        if (accept) begin
          res_d        = '0;
          scan_cnt_d   = '0;
          issue_done_d = 1'b0;
          found_d      = 1'b0;
          free_found_d = 1'b0;
          if (nsem_pkg::func_e'(in_data_i[nsem_pkg::FuncLo +: nsem_pkg::FuncW])
              == nsem_pkg::FUNC_FREE) begin
            state_d = nsem_pkg::S_EXEC;
          end else begin
            state_d = nsem_pkg::S_SCAN;
          end
        end
      end
      nsem_pkg::S_SCAN: begin
        if (!issue_done_q) begin
          ent_re    = 1'b1;
          cmp_v_d   = 1'b1;
          cmp_idx_d = scan_cnt_q;
          if (scan_cnt_q == IW'(NUM_ENTRIES - 1)) begin
            issue_done_d = 1'b1;
          end else begin
            scan_cnt_d = scan_cnt_q + IW'(1);
          end
        end
        if (hit && !found_q) begin
          found_d   = 1'b1;
          m_idx_d   = cmp_idx_q;
          m_count_d = ent_count;
          m_head_d  = ent_head;
          m_fill_d  = ent_fill;
        end
        if (free_hit && !free_found_q) begin
          free_found_d = 1'b1;
          free_idx_d   = cmp_idx_q;
        end
        if (cmp_v_q && (cmp_idx_q == IW'(NUM_ENTRIES - 1))) begin
          state_d = nsem_pkg::S_EXEC;
        end
      end
      nsem_pkg::S_EXEC: begin
        state_d = nsem_pkg::S_RESP;
        unique case (op_func_q)
          nsem_pkg::FUNC_CREATE: begin
            if (found_q) begin
              res_d.status       = nsem_pkg::ST_EXISTS;
              res_d.result_index = nsem_pkg::IdxW'(m_idx_q);
            end else if (free_found_q) begin
              ent_we    = 1'b1;
              ent_waddr = free_idx_q;
              ent_wdata = {FW'(0), QW'(0), CW'(op_init_q), op_name_q, op_owner_q};
              used_set  = 1'b1;
              used_idx  = free_idx_q;
              res_d.result_index = nsem_pkg::IdxW'(free_idx_q);
            end else begin
              res_d.status = nsem_pkg::ST_FULL;
            end
          end
          nsem_pkg::FUNC_WAIT: begin
            if (!found_q) begin
              res_d.status = nsem_pkg::ST_NOTFOUND;
            end else begin
              res_d.result_index = nsem_pkg::IdxW'(m_idx_q);
              if (m_count_q <= 0) begin
                if (m_fill_q >= FW'(QUEUE_DEPTH)) begin
                  res_d.status = nsem_pkg::ST_QFULL;
                end else begin
                  wt_we     = 1'b1;
                  ent_we    = 1'b1;
                  ent_wdata = {m_fill_q + FW'(1), m_head_q, m_count_q - CW'(1),
                               op_name_q, op_owner_q};
                  res_d.caller_blocked = 1'b1;
                end
              end else begin
                ent_we    = 1'b1;
                ent_wdata = {m_fill_q, m_head_q, m_count_q - CW'(1), op_name_q, op_owner_q};
              end
            end
          end
          nsem_pkg::FUNC_SIGNAL: begin
            if (!found_q) begin
              res_d.status = nsem_pkg::ST_NOTFOUND;
            end else begin
              res_d.result_index = nsem_pkg::IdxW'(m_idx_q);
              ent_we = 1'b1;
              if ((sig_count <= 0) && (m_fill_q != '0)) begin
                wt_re     = 1'b1;
                ent_wdata = {m_fill_q - FW'(1), head_nx, sig_count, op_name_q, op_owner_q};
                res_d.woken_valid = 1'b1;
                state_d = nsem_pkg::S_WREAD;
              end else begin
                ent_wdata = {m_fill_q, m_head_q, sig_count, op_name_q, op_owner_q};
              end
            end
          end
          nsem_pkg::FUNC_FREE: begin
            if (32'(op_target_q) >= NUM_ENTRIES) begin
              res_d.status = nsem_pkg::ST_NOTFOUND;
            end else begin
              used_clr = 1'b1;
              used_idx = IW'(op_target_q);
              res_d.result_index = op_target_q;
            end
          end
          default: ;
        endcase
      end
      nsem_pkg::S_WREAD: begin
        res_d.woken_env = nsem_pkg::EnvW'(wt_rdata);
        state_d = nsem_pkg::S_RESP;
      end
      nsem_pkg::S_RESP: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = nsem_pkg::S_IDLE;
        end
      end
      default: state_d = nsem_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= nsem_pkg::S_IDLE;
      scan_cnt_q   <= '0;
      issue_done_q <= 1'b0;
      cmp_v_q      <= 1'b0;
      cmp_idx_q    <= '0;
      found_q      <= 1'b0;
      free_found_q <= 1'b0;
      free_idx_q   <= '0;
      for (int i = 0; i < NUM_ENTRIES; i++) begin
        used_q[i] <= 1'b0;
      end
    end else begin
      state_q      <= state_d;
      scan_cnt_q   <= scan_cnt_d;
      issue_done_q <= issue_done_d;
      cmp_v_q      <= cmp_v_d;
      cmp_idx_q    <= cmp_idx_d;
      found_q      <= found_d;
      free_found_q <= free_found_d;
      free_idx_q   <= free_idx_d;
      if (used_set) begin
        used_q[used_idx] <= 1'b1;
      end else if (used_clr) begin
        used_q[used_idx] <= 1'b0;
      end
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk_i) begin
    m_idx_q   <= m_idx_d;
    m_count_q <= m_count_d;
    m_head_q  <= m_head_d;
    m_fill_q  <= m_fill_d;
    res_q     <= res_d;
    if (accept) begin
      op_func_q   <= nsem_pkg::func_e'(in_data_i[nsem_pkg::FuncLo +: nsem_pkg::FuncW]);
      op_owner_q  <= in_data_i[nsem_pkg::OwnerLo +: EW];
      op_name_q   <= in_data_i[nsem_pkg::NameLo +: NB];
      op_init_q   <= in_data_i[nsem_pkg::InitLo +: nsem_pkg::InitW];
      op_caller_q <= in_data_i[nsem_pkg::CallerLo +: EW];
      op_target_q <= in_data_i[nsem_pkg::TargetLo +: nsem_pkg::TargetW];
    end
  end

  assign res_o = res_q;

  nsem_ram #(
    .WIDTH (EntW),
    .DEPTH (NUM_ENTRIES)
  ) u_entry_ram (
    .clk_i   (clk_i),
    .we_i    (ent_we),
    .waddr_i (ent_waddr),
    .wdata_i (ent_wdata),
    .re_i    (ent_re),
    .raddr_i (ent_raddr),
    .rdata_o (ent_rdata)
  );

  nsem_ram #(
    .WIDTH (EW),
    .DEPTH (WD)
  ) u_waiter_ram (
    .clk_i   (clk_i),
    .we_i    (wt_we),
    .waddr_i (wt_waddr),
    .wdata_i (wt_wdata),
    .re_i    (wt_re),
    .raddr_i (wt_raddr),
    .rdata_o (wt_rdata)
  );

endmodule

>>> hdl/nsem_checker.sv
// port-level checker for the named semaphore table, bound to the top level
// depends on nsem_pkg and named_counting_semaphore_table_assert.svh
`include "named_counting_semaphore_table_assert.svh"

module nsem_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic [nsem_pkg::InDataW-1:0]  s_axis_tdata,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [nsem_pkg::OutDataW-1:0] m_axis_tdata
);

  logic [nsem_pkg::StatusW-1:0] st;
  logic                         unused_ok;

  assign st        = m_axis_tdata[2:0];
  assign unused_ok = ^s_axis_tdata;

  `NCST_ASSERT_NXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
    m_axis_tvalid && $stable(m_axis_tdata), "result beat changed while stalled")
  `NCST_ASSERT_NXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready && (unused_ok || !unused_ok),
    !s_axis_tready, "new beat taken while an operation runs")
  `NCST_ASSERT_IMP(a_status_code, m_axis_tvalid, st <= nsem_pkg::ST_QFULL, "bad status code")
  `NCST_ASSERT_IMP(a_no_idx_on_miss,
    m_axis_tvalid && (st == nsem_pkg::ST_FULL || st == nsem_pkg::ST_NOTFOUND),
    m_axis_tdata[8:3] == 6'd0, "index or flags set on a miss")
  `NCST_ASSERT_IMP(a_flags_excl, m_axis_tvalid && m_axis_tdata[7],
    !m_axis_tdata[8] && (st == nsem_pkg::ST_OK), "blocked and woken together")

endmodule

bind named_counting_semaphore_table nsem_checker u_nsem_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
